FILE: rtl/baro_temp_pressure_compensation_assert.svh
// ----------------------------------------------------------------------------
// Barometric compensation assertion macros
// Shared concurrent assertion forms for the compensation block checkers.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define BTPC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("btpc assertion failed");

// Checked on every rising clock edge, reset included.
`define BTPC_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("btpc reset assertion failed");

`endif

FILE: rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Types, constants and helper functions shared by the compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int unsigned DATA_W    = 64;
    localparam int unsigned TEMP_W    = 32;
    localparam int unsigned RAW_W     = 20;
    localparam int unsigned CALIB_W   = 48;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned DIGIT_W   = 16;
    localparam int unsigned MUL_STEPS = DATA_W / DIGIT_W;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CALIB  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_A = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_B = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_C = 8'd3;

    localparam logic [DATA_W-1:0] FINE_OFFSET = 64'd128000;
    localparam logic [DATA_W-1:0] RAW_BASE    = 64'd1048576;
    localparam logic [DATA_W-1:0] PRESS_SCALE = 64'd3125;
    localparam logic [DATA_W-1:0] V1_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [TEMP_W-1:0] TEMP_ROUND  = 32'd128;

    typedef enum logic [0:0] {
        MDU_OP_MUL,
        MDU_OP_DIV
    } mdu_op_t;

    typedef struct packed {
        logic    start;
        mdu_op_t op;
    } mdu_req_t;

    typedef struct packed {
        logic done;
    } mdu_rsp_t;

    typedef enum logic [2:0] {
        MDU_IDLE,
        MDU_MUL,
        MDU_DIV,
        MDU_FIX,
        MDU_DONE
    } mdu_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_SUM,
        ST_OUT
    } seq_state_t;

    typedef enum logic [3:0] {
        STP_T0,
        STP_T1,
        STP_T2,
        STP_P0,
        STP_P1,
        STP_P2,
        STP_P3,
        STP_P4,
        STP_P5,
        STP_P6,
        STP_P7,
        STP_P8,
        STP_P9,
        STP_P10
    } step_t;

    function automatic logic [DATA_W-1:0] asr64(input logic [DATA_W-1:0] x,
                                               input int unsigned sh);
        return DATA_W'($signed(x) >>> sh);
    endfunction

    function automatic logic [TEMP_W-1:0] asr32(input logic [TEMP_W-1:0] x,
                                               input int unsigned sh);
        return TEMP_W'($signed(x) >>> sh);
    endfunction

    function automatic logic [DATA_W-1:0] sext16(input logic [15:0] w);
        return {{(DATA_W-16){w[15]}}, w};
    endfunction

endpackage

FILE: rtl/btpc_mdu.sv
// ----------------------------------------------------------------------------
// Shared multiply and divide unit
// 64-bit multiply in 16-bit digits and signed restoring division, one step
// per cycle; result holds until the next start.
// ----------------------------------------------------------------------------
module btpc_mdu import btpc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  mdu_req_t          req,
    input  logic [DATA_W-1:0] opa,
    input  logic [DATA_W-1:0] opb,
    output mdu_rsp_t          rsp,
    output logic [DATA_W-1:0] result
);

    mdu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] mcand_reg, mcand_next;
    logic [DATA_W-1:0] mplier_reg, mplier_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic              neg_reg, neg_next;

    logic [DATA_W-1:0] partial;
    logic [DATA_W-1:0] rem_shift;
    logic [DATA_W-1:0] rem_diff;
    logic              rem_ge;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;

    assign partial   = DATA_W'(mcand_reg * mplier_reg[DIGIT_W-1:0]);
    assign rem_shift = {rem_reg[DATA_W-2:0], mcand_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - mplier_reg;
    assign rem_ge    = (rem_shift >= mplier_reg);
    assign abs_a     = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
    assign abs_b     = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
    assign result    = acc_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        rsp.done    = 1'b0;
        case (state_reg)
            MDU_IDLE: begin
                if (req.start) begin
                    cnt_next = '0;
                    if (req.op == MDU_OP_DIV) begin
                        mcand_next  = abs_a;
                        mplier_next = abs_b;
                        rem_next    = '0;
                        neg_next    = opa[DATA_W-1] ^ opb[DATA_W-1];
                        state_next  = MDU_DIV;
                    end else begin
                        acc_next    = '0;
                        mcand_next  = opa;
                        mplier_next = opb;
                        state_next  = MDU_MUL;
                    end
                end
            end
            MDU_MUL: begin
                acc_next    = acc_reg + partial;
                mcand_next  = mcand_reg << DIGIT_W;
                mplier_next = mplier_reg >> DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    state_next = MDU_DONE;
                end
            end
            MDU_DIV: begin
                rem_next   = rem_ge ? rem_diff : rem_shift;
                mcand_next = {mcand_reg[DATA_W-2:0], rem_ge};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = MDU_FIX;
                end
            end
            MDU_FIX: begin
                acc_next   = neg_reg ? (~mcand_reg + 1'b1) : mcand_reg;
                state_next = MDU_DONE;
            end
            MDU_DONE: begin
                rsp.done   = 1'b1;
                state_next = MDU_IDLE;
            end
            default: begin
                state_next = MDU_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MDU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
    end

endmodule

FILE: rtl/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Integer compensation of raw 20-bit temperature and pressure samples.
// ----------------------------------------------------------------------------
// One sample is worked on at a time, and s_ready is high only while the block
// is idle. All products and the division run on one shared multiply/divide
// unit under a step sequencer: a multiply runs as issue, four 16-bit digit
// steps and completion, the division as issue, one quotient bit per cycle,
// sign fix and completion. Before its result goes to m_valid, a temperature
// sample runs three multiplies, a pressure sample ten multiplies, the division
// and a final sum, and a pressure sample whose divisor is zero six multiplies.
// A finished result waits in an output register, so the next sample is taken
// while it is still pending; a later result waits until that register is
// free.
module baro_temp_pressure_compensation import btpc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CALIB_W-1:0]       cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic [RAW_W-1:0]         s_raw_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_result_kind,
    output logic signed [TEMP_W-1:0] m_temperature_centi,
    output logic [TEMP_W-1:0]        m_pressure_q24_8,
    output logic                     m_divide_fault
);

    seq_state_t         state_reg, state_next;
    step_t              step_reg, step_next;
    logic               kind_reg, kind_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [DATA_W-1:0]  ra_reg, ra_next;
    logic [DATA_W-1:0]  rb_reg, rb_next;
    logic [DATA_W-1:0]  rc_reg, rc_next;
    logic [TEMP_W-1:0]  fine_reg, fine_next;
    logic               fault_reg, fault_next;

    logic [CALIB_W-1:0] tcal_reg, tcal_next;
    logic [CALIB_W-1:0] pcal_a_reg, pcal_a_next;
    logic [CALIB_W-1:0] pcal_b_reg, pcal_b_next;
    logic [CALIB_W-1:0] pcal_c_reg, pcal_c_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_kind_reg, m_kind_next;
    logic [TEMP_W-1:0]  m_temp_reg, m_temp_next;
    logic [TEMP_W-1:0]  m_press_reg, m_press_next;
    logic               m_fault_reg, m_fault_next;

    mdu_req_t           mdu_req;
    mdu_rsp_t           mdu_rsp;
    logic [DATA_W-1:0]  mdu_opa;
    logic [DATA_W-1:0]  mdu_opb;
    logic [DATA_W-1:0]  mdu_res;

    logic [TEMP_W-1:0]  t1;
    logic [TEMP_W-1:0]  t_x;
    logic [TEMP_W-1:0]  t_d;
    logic [TEMP_W-1:0]  fine_upd;
    logic [TEMP_W-1:0]  fine_x5;
    logic [TEMP_W-1:0]  temp_out;
    logic [DATA_W-1:0]  v1;
    logic [DATA_W-1:0]  p_base;
    logic [DATA_W-1:0]  div_num;
    logic [DATA_W-1:0]  v1_final;
    logic [DATA_W-1:0]  press_full;

    btpc_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mdu_req),
        .opa     (mdu_opa),
        .opb     (mdu_opb),
        .rsp     (mdu_rsp),
        .result  (mdu_res)
    );

    assign t1         = {16'd0, tcal_reg[15:0]};
    assign t_x        = {15'd0, raw_reg[RAW_W-1:3]} - {t1[TEMP_W-2:0], 1'b0};
    assign t_d        = {16'd0, raw_reg[RAW_W-1:4]} - t1;
    assign fine_upd   = rc_reg[TEMP_W-1:0] + asr32(mdu_res[TEMP_W-1:0], 14);
    assign fine_x5    = fine_reg + {fine_reg[TEMP_W-3:0], 2'b00} + TEMP_ROUND;
    assign temp_out   = asr32(fine_x5, 8);
    assign v1         = {{(DATA_W-TEMP_W){fine_reg[TEMP_W-1]}}, fine_reg} - FINE_OFFSET;
    assign p_base     = RAW_BASE - {{(DATA_W-RAW_W){1'b0}}, raw_reg};
    assign div_num    = (p_base << 31) - rb_reg;
    assign v1_final   = asr64(mdu_res, 33);
    assign press_full = asr64(ra_reg, 8) + (sext16(pcal_c_reg[15:0]) << 4);

    assign s_ready             = (state_reg == ST_IDLE);
    assign cfg_ready           = 1'b1;
    assign m_valid             = m_valid_reg;
    assign m_result_kind       = m_kind_reg;
    assign m_temperature_centi = m_temp_reg;
    assign m_pressure_q24_8    = m_press_reg;
    assign m_divide_fault      = m_fault_reg;

    always_comb begin
        mdu_opa    = '0;
        mdu_opb    = '0;
        case (step_reg)
            STP_T0: begin
                mdu_opa = {32'd0, t_x};
                mdu_opb = sext16(tcal_reg[31:16]);
            end
            STP_T1: begin
                mdu_opa = {32'd0, t_d};
                mdu_opb = {32'd0, t_d};
            end
            STP_T2: begin
                mdu_opa = {32'd0, asr32(ra_reg[TEMP_W-1:0], 12)};
                mdu_opb = sext16(tcal_reg[47:32]);
            end
            STP_P0: begin
                mdu_opa = v1;
                mdu_opb = v1;
            end
            STP_P1: begin
                mdu_opa = ra_reg;
                mdu_opb = sext16(pcal_b_reg[47:32]);
            end
            STP_P2: begin
                mdu_opa = v1;
                mdu_opb = sext16(pcal_b_reg[31:16]);
            end
            STP_P3: begin
                mdu_opa = ra_reg;
                mdu_opb = sext16(pcal_a_reg[47:32]);
            end
            STP_P4: begin
                mdu_opa = v1;
                mdu_opb = sext16(pcal_a_reg[31:16]);
            end
            STP_P5: begin
                mdu_opa = V1_BIAS + ra_reg;
                mdu_opb = {48'd0, pcal_a_reg[15:0]};
            end
            STP_P6: begin
                mdu_opa = div_num;
                mdu_opb = PRESS_SCALE;
            end
            STP_P7: begin
                mdu_opa = rc_reg;
                mdu_opb = ra_reg;
            end
            STP_P8: begin
                mdu_opa = sext16(pcal_c_reg[47:32]);
                mdu_opb = asr64(rc_reg, 13);
            end
            STP_P9: begin
                mdu_opa = ra_reg;
                mdu_opb = asr64(rc_reg, 13);
            end
            STP_P10: begin
                mdu_opa = sext16(pcal_c_reg[31:16]);
                mdu_opb = rc_reg;
            end
            default: begin
                mdu_opa = '0;
                mdu_opb = '0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        kind_next     = kind_reg;
        raw_next      = raw_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        rc_next       = rc_reg;
        fine_next     = fine_reg;
        fault_next    = fault_reg;
        tcal_next     = tcal_reg;
        pcal_a_next   = pcal_a_reg;
        pcal_b_next   = pcal_b_reg;
        pcal_c_next   = pcal_c_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_temp_next   = m_temp_reg;
        m_press_next  = m_press_reg;
        m_fault_next  = m_fault_reg;
        mdu_req.start = 1'b0;
        mdu_req.op    = (step_reg == STP_P7) ? MDU_OP_DIV : MDU_OP_MUL;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_TEMP_CALIB:  tcal_next   = cfg_data;
                CFG_PRESS_CAL_A: pcal_a_next = cfg_data;
                CFG_PRESS_CAL_B: pcal_b_next = cfg_data;
                CFG_PRESS_CAL_C: pcal_c_next = cfg_data;
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    raw_next   = s_raw_sample;
                    fault_next = 1'b0;
                    step_next  = s_kind ? STP_P0 : STP_T0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                mdu_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT: begin
                if (mdu_rsp.done) begin
                    state_next = ST_ISSUE;
                    case (step_reg)
                        STP_T0: begin
                            rc_next   = {32'd0, asr32(mdu_res[TEMP_W-1:0], 11)};
                            step_next = STP_T1;
                        end
                        STP_T1: begin
                            ra_next   = mdu_res;
                            step_next = STP_T2;
                        end
                        STP_T2: begin
                            fine_next  = fine_upd;
                            state_next = ST_OUT;
                        end
                        STP_P0: begin
                            ra_next   = mdu_res;
                            step_next = STP_P1;
                        end
                        STP_P1: begin
                            rb_next   = mdu_res;
                            step_next = STP_P2;
                        end
                        STP_P2: begin
                            rb_next   = rb_reg + (mdu_res << 17)
                                      + (sext16(pcal_b_reg[15:0]) << 35);
                            step_next = STP_P3;
                        end
                        STP_P3: begin
                            ra_next   = mdu_res;
                            step_next = STP_P4;
                        end
                        STP_P4: begin
                            ra_next   = asr64(ra_reg, 8) + (mdu_res << 12);
                            step_next = STP_P5;
                        end
                        STP_P5: begin
                            ra_next = v1_final;
                            if (v1_final == '0) begin
                                fault_next = 1'b1;
                                state_next = ST_OUT;
                            end else begin
                                step_next = STP_P6;
                            end
                        end
                        STP_P6: begin
                            rc_next   = mdu_res;
                            step_next = STP_P7;
                        end
                        STP_P7: begin
                            rc_next   = mdu_res;
                            step_next = STP_P8;
                        end
                        STP_P8: begin
                            ra_next   = mdu_res;
                            step_next = STP_P9;
                        end
                        STP_P9: begin
                            ra_next   = asr64(mdu_res, 25);
                            step_next = STP_P10;
                        end
                        STP_P10: begin
                            rb_next    = asr64(mdu_res, 19);
                            state_next = ST_SUM;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                ra_next    = rc_reg + ra_reg + rb_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = kind_reg;
                    if (kind_reg) begin
                        m_temp_next  = '0;
                        m_press_next = fault_reg ? '0 : press_full[TEMP_W-1:0];
                        m_fault_next = fault_reg;
                    end else begin
                        m_temp_next  = temp_out;
                        m_press_next = '0;
                        m_fault_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fine_reg    <= '0;
            tcal_reg    <= '0;
            pcal_a_reg  <= '0;
            pcal_b_reg  <= '0;
            pcal_c_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fine_reg    <= fine_next;
            tcal_reg    <= tcal_next;
            pcal_a_reg  <= pcal_a_next;
            pcal_b_reg  <= pcal_b_next;
            pcal_c_reg  <= pcal_c_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg    <= step_next;
        kind_reg    <= kind_next;
        raw_reg     <= raw_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        rc_reg      <= rc_next;
        fault_reg   <= fault_next;
        m_kind_reg  <= m_kind_next;
        m_temp_reg  <= m_temp_next;
        m_press_reg <= m_press_next;
        m_fault_reg <= m_fault_next;
    end

endmodule

FILE: rtl/btpc_checker.sv
// ----------------------------------------------------------------------------
// Barometric compensation port checker
// Watches the ports of the compensation block over time.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_assert.svh"

module btpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic [31:0] m_temperature_centi,
    input logic [31:0] m_pressure_q24_8,
    input logic        m_divide_fault
);

    // A sample in work blocks the input side until the sequence ends.
    `BTPC_ASSERT(a_busy_after_xfer, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    `BTPC_ASSERT(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_temperature_centi) && $stable(m_pressure_q24_8))

    `BTPC_ASSERT(a_temp_fields, aclk, aresetn, m_valid && !m_result_kind |-> m_pressure_q24_8 == 32'd0 && !m_divide_fault)

    `BTPC_ASSERT(a_press_fields, aclk, aresetn, m_valid && m_result_kind |-> m_temperature_centi == 32'd0 && (!m_divide_fault || m_pressure_q24_8 == 32'd0))

    `BTPC_ASSERT_NR(a_reset_empties, aclk, !aresetn |=> !m_valid)

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_result_kind       (m_result_kind),
    .m_temperature_centi (m_temperature_centi),
    .m_pressure_q24_8    (m_pressure_q24_8),
    .m_divide_fault      (m_divide_fault)
);
